FILE: rtl/rabs_pkg.sv
package rabs_pkg;

    typedef enum logic [1:0] {
        MODE_LEARN_FIRST = 2'd0,
        MODE_LEARN_ADD   = 2'd1,
        MODE_LEARN_LAST  = 2'd2,
        MODE_DETECT      = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] pixel_index;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } pix_t;

    typedef struct packed {
        logic [15:0] pixel_out;
        logic [7:0]  red_diff;
        logic [7:0]  green_diff;
        logic [7:0]  blue_diff;
    } res_t;

    // configuration register indexes
    localparam logic [0:0] CFG_LEARN_FRAMES = 1'b0;
    localparam logic [0:0] CFG_ALPHA_Q8     = 1'b1;

    localparam logic [8:0] LEARN_FRAMES_RESET = 9'd1;
    localparam logic [8:0] ALPHA_RESET        = 9'd243;
    localparam logic [8:0] ALPHA_MAX          = 9'd256;

    localparam int CHANNELS  = 3;
    localparam int DIV_STEPS = 8;   // quotient bits below the saturation point

endpackage

FILE: rtl/running_average_background_subtractor.sv
// Throughput: one pixel per clock while the skid is empty, any mix of modes and indexes.
// A pixel passes stage A, divider stages D0..D8 and the output register to res_valid;
//   depth is set by the restoring divider that forms the learned average.
// Each store reads a stage ahead of its write, closed by a one-entry write-forward.
// Reset (rst_n, async): clears pipeline valids, output/skid and config registers;
//   the background and sum stores are not initialized and have no clearing pass.
module running_average_background_subtractor #(
    parameter int PIXEL_COUNT      = 65536,
    parameter int MAX_LEARN_FRAMES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              px_valid,
    output logic              px_ready,
    input  rabs_pkg::pix_t    px_data,
    output logic              res_valid,
    input  logic              res_ready,
    output rabs_pkg::res_t    res_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [8:0]        cfg_data
);

    // Store depth: pixel_index is 16 bits, so no more than 64K entries are reachable.
    localparam int DEPTH = (PIXEL_COUNT < 65536) ? PIXEL_COUNT : 65536;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Largest effective frame count: MAX_LEARN_FRAMES, limited to what 9 bits can hold.
    localparam logic [8:0] N_CAP =
        (MAX_LEARN_FRAMES > 511) ? 9'd511 : 9'(MAX_LEARN_FRAMES);
    localparam int NS = rabs_pkg::DIV_STEPS;
    localparam int NC = rabs_pkg::CHANNELS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [8:0] learn_frames_reg;
    logic [8:0] alpha_q8_reg;
    logic [8:0] n_eff;
    logic [8:0] alpha_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_frames_reg <= rabs_pkg::LEARN_FRAMES_RESET;
            alpha_q8_reg     <= rabs_pkg::ALPHA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rabs_pkg::CFG_LEARN_FRAMES: learn_frames_reg <= cfg_data;
                rabs_pkg::CFG_ALPHA_Q8:     alpha_q8_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Zero frames counts as one; counts above the cap are clamped.
    always_comb
    begin
        if (learn_frames_reg == 9'd0)
            n_eff = 9'd1;
        else if (32'(learn_frames_reg) > MAX_LEARN_FRAMES)
            n_eff = N_CAP;
        else
            n_eff = learn_frames_reg;
        alpha_eff = (alpha_q8_reg > rabs_pkg::ALPHA_MAX) ? rabs_pkg::ALPHA_MAX
                                                          : alpha_q8_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves together unless the skid is full.
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;
    logic skid_valid_reg;
    rabs_pkg::res_t out_reg;
    rabs_pkg::res_t skid_reg;

    assign adv      = !skid_valid_reg;
    assign px_ready = adv;

    logic          in_range;
    logic [AW-1:0] px_addr;

    assign in_range = (32'(px_data.pixel_index) < 32'(PIXEL_COUNT));
    assign px_addr  = px_data.pixel_index[AW-1:0];

    // ------------------------------------------------------------------
    // Stage A: sum store read data arrives, new sums computed and written.
    // ------------------------------------------------------------------
    logic            a_valid_reg;
    rabs_pkg::mode_t a_mode_reg;
    logic [15:0]     a_idx_reg;
    logic [23:0]     a_px_reg;      // {blue, green, red}
    logic [AW-1:0]   a_addr;

    logic [47:0]     sum_mem [DEPTH];
    logic [47:0]     sum_rd_reg;
    logic            sfw_valid_reg;
    logic [AW-1:0]   sfw_addr_reg;
    logic [47:0]     sfw_data_reg;

    logic [47:0]     sum_cur;
    logic [47:0]     sum_new;
    logic            restart;
    logic            sum_we;

    assign a_addr = a_idx_reg[AW-1:0];

    always_comb
    begin
        // Most recent sum write wins over the (possibly stale) memory read.
        sum_cur = (sfw_valid_reg && (sfw_addr_reg == a_addr)) ? sfw_data_reg : sum_rd_reg;
        restart = (a_mode_reg == rabs_pkg::MODE_LEARN_FIRST) ||
                  ((a_mode_reg == rabs_pkg::MODE_LEARN_LAST) && (n_eff == 9'd1));
        for (int c = 0; c < NC; c++)
        begin
            sum_new[16*c +: 16] = restart ? {8'd0, a_px_reg[8*c +: 8]}
                                          : sum_cur[16*c +: 16] + {8'd0, a_px_reg[8*c +: 8]};
        end
        sum_we = adv && a_valid_reg && (a_mode_reg != rabs_pkg::MODE_DETECT);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            sum_rd_reg <= sum_mem[px_addr];
        if (sum_we)
            sum_mem[a_addr] <= sum_new;
    end

    // ------------------------------------------------------------------
    // Divider stages D0..D8: restoring division of each 16-bit sum by n.
    // D0 holds the saturation flag and the upper byte as partial remainder;
    // each stage brings down one low bit and produces one quotient bit.
    // ------------------------------------------------------------------
    logic [NS:0]     dv_reg;
    rabs_pkg::mode_t dmode_reg [NS+1];
    logic [15:0]     didx_reg  [NS+1];
    logic [23:0]     dpx_reg   [NS+1];
    logic [NC-1:0]   dsat_reg  [NS+1];
    logic [7:0]      dql_reg   [NS+1][NC];  // low bits shift out, quotient bits shift in
    logic [8:0]      dr_reg    [NS][NC];    // partial remainder

    logic [9:0]      step_rr   [NS][NC];
    logic            step_ge   [NS][NC];

    always_comb
    begin
        for (int j = 0; j < NS; j++)
        begin
            for (int c = 0; c < NC; c++)
            begin
                step_rr[j][c] = {dr_reg[j][c], dql_reg[j][c][7]};
                step_ge[j][c] = (step_rr[j][c] >= {1'b0, n_eff});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_mode_reg <= px_data.mode;
            a_idx_reg  <= px_data.pixel_index;
            a_px_reg   <= {px_data.blue_in, px_data.green_in, px_data.red_in};

            dmode_reg[0] <= a_mode_reg;
            didx_reg[0]  <= a_idx_reg;
            dpx_reg[0]   <= a_px_reg;
            for (int c = 0; c < NC; c++)
            begin
                dsat_reg[0][c] <= ({1'b0, sum_new[16*c+8 +: 8]} >= n_eff);
                dr_reg[0][c]   <= {1'b0, sum_new[16*c+8 +: 8]};
                dql_reg[0][c]  <= sum_new[16*c +: 8];
            end

            for (int j = 1; j <= NS; j++)
            begin
                dmode_reg[j] <= dmode_reg[j-1];
                didx_reg[j]  <= didx_reg[j-1];
                dpx_reg[j]   <= dpx_reg[j-1];
                dsat_reg[j]  <= dsat_reg[j-1];
                for (int c = 0; c < NC; c++)
                begin
                    dql_reg[j][c] <= {dql_reg[j-1][c][6:0], step_ge[j-1][c]};
                    if (j < NS)
                    begin
                        dr_reg[j][c] <= step_ge[j-1][c]
                                        ? 9'(step_rr[j-1][c] - {1'b0, n_eff})
                                        : step_rr[j-1][c][8:0];
                    end
                end
            end
        end
        if (sum_we)
        begin
            sfw_addr_reg <= a_addr;
            sfw_data_reg <= sum_new;
        end
    end

    // ------------------------------------------------------------------
    // Stage D8: background read data arrives (read issued as the item left
    // D7), new background formed and written, detect result produced.
    // ------------------------------------------------------------------
    logic [23:0]     bg_mem [DEPTH];
    logic [23:0]     bg_rd_reg;
    logic            bfw_valid_reg;
    logic [AW-1:0]   bfw_addr_reg;
    logic [23:0]     bfw_data_reg;

    logic [AW-1:0]   w_addr;
    logic [AW-1:0]   pre_addr;
    logic [23:0]     bg_cur;
    logic [23:0]     bg_new;
    logic [23:0]     diff;
    logic            is_detect;
    logic            bg_we;
    logic            res_fire;
    rabs_pkg::res_t  res_new;

    logic [7:0]        ch_b     [NC];
    logic [7:0]        ch_p     [NC];
    logic signed [9:0] ch_delta [NC];
    logic signed [19:0] ch_blend [NC];

    assign w_addr   = didx_reg[NS][AW-1:0];
    assign pre_addr = didx_reg[NS-1][AW-1:0];

    always_comb
    begin
        bg_cur    = (bfw_valid_reg && (bfw_addr_reg == w_addr)) ? bfw_data_reg : bg_rd_reg;
        is_detect = (dmode_reg[NS] == rabs_pkg::MODE_DETECT);
        for (int c = 0; c < NC; c++)
        begin
            ch_b[c]     = bg_cur[8*c +: 8];
            ch_p[c]     = dpx_reg[NS][8*c +: 8];
            diff[8*c +: 8] = (ch_p[c] >= ch_b[c]) ? (ch_p[c] - ch_b[c]) : (ch_b[c] - ch_p[c]);
            // alpha*b + (256-alpha)*p == 256*p + alpha*(b-p)
            ch_delta[c] = signed'({2'b00, ch_b[c]}) - signed'({2'b00, ch_p[c]});
            ch_blend[c] = signed'({4'd0, ch_p[c], 8'd0})
                        + signed'({1'b0, alpha_eff}) * ch_delta[c];
            bg_new[8*c +: 8] = is_detect ? ch_blend[c][15:8]
                             : (dsat_reg[NS][c] ? 8'hFF : dql_reg[NS][c]);
        end
        bg_we    = adv && dv_reg[NS] &&
                   (is_detect || (dmode_reg[NS] == rabs_pkg::MODE_LEARN_LAST));
        res_fire = adv && dv_reg[NS] && is_detect;

        res_new.pixel_out  = didx_reg[NS];
        res_new.red_diff   = diff[7:0];
        res_new.green_diff = diff[15:8];
        res_new.blue_diff  = diff[23:16];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            bg_rd_reg <= bg_mem[pre_addr];
        if (bg_we)
            bg_mem[w_addr] <= bg_new;
    end

    always_ff @(posedge clk)
    begin
        if (bg_we)
        begin
            bfw_addr_reg <= w_addr;
            bfw_data_reg <= bg_new;
        end
    end

    // ------------------------------------------------------------------
    // Control state: stage valids and forward valids.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            dv_reg        <= '0;
            sfw_valid_reg <= 1'b0;
            bfw_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                // out-of-range pixels are dropped here with no state change
                a_valid_reg <= px_valid && in_range;
                dv_reg      <= {dv_reg[NS-1:0], a_valid_reg};
            end
            if (sum_we)
                sfw_valid_reg <= 1'b1;
            if (bg_we)
                bfw_valid_reg <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output register plus skid: the pipeline keeps taking pixels while a
    // result waits; it halts only once both hold a transaction.
    // ------------------------------------------------------------------
    logic out_valid_next;
    logic skid_valid_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && res_ready)
        begin
            if (skid_valid_reg)
                skid_valid_next = 1'b0;
            else
                out_valid_next = 1'b0;
        end
        if (res_fire)
        begin
            if (out_valid_reg && !res_ready)
                skid_valid_next = 1'b1;
            else
                out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && res_ready && skid_valid_reg)
            out_reg <= skid_reg;
        if (res_fire)
        begin
            if (out_valid_reg && !res_ready)
                skid_reg <= res_new;
            else
                out_reg <= res_new;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

endmodule

FILE: dv/running_average_background_subtractor_tb.sv
module running_average_background_subtractor_tb;

    localparam int PIXEL_COUNT      = 65536;
    localparam int MAX_LEARN_FRAMES = 256;
    localparam int CYCLE_LIMIT      = 500000;
    // quiet time before a config write or the verdict
    localparam int DRAIN_PAD        = 20;
    localparam int MAX_REPORTS      = 10;
    localparam int RANDOM_PHASES    = 7;

    typedef struct packed {
        logic [0:0] index;
        logic [8:0] data;
    } cfg_write_t;

    // ------------------------------------------------------------------
    // DUT ports: every input holds a known value from time zero
    // ------------------------------------------------------------------
    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           px_valid  = 1'b0;
    logic           px_ready;
    rabs_pkg::pix_t px_data   = '0;
    logic           res_valid;
    logic           res_ready = 1'b0;
    rabs_pkg::res_t res_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [0:0]     cfg_index = rabs_pkg::CFG_LEARN_FRAMES;
    logic [8:0]     cfg_data  = '0;

    running_average_background_subtractor #(
        .PIXEL_COUNT      (PIXEL_COUNT),
        .MAX_LEARN_FRAMES (MAX_LEARN_FRAMES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .px_valid  (px_valid),
        .px_ready  (px_ready),
        .px_data   (px_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block: per-pixel background and channel sums,
    // plus the two registers as last written. Updated at each accepted
    // transaction, in acceptance order.
    // ------------------------------------------------------------------
    bit [7:0]       bg_mem  [0:PIXEL_COUNT-1][0:rabs_pkg::CHANNELS-1];
    bit [15:0]      sum_mem [0:PIXEL_COUNT-1][0:rabs_pkg::CHANNELS-1];
    bit [8:0]       frames_cfg = rabs_pkg::LEARN_FRAMES_RESET;
    bit [8:0]       alpha_cfg  = rabs_pkg::ALPHA_RESET;
    rabs_pkg::res_t expected_diffs[$];

    // ------------------------------------------------------------------
    // Stimulus bookkeeping
    // ------------------------------------------------------------------
    rabs_pkg::pix_t pending_pixels[$];
    cfg_write_t     pending_cfg[$];
    int unsigned    px_issued, px_taken, cfg_issued, cfg_taken;
    int unsigned    results_checked, mismatches, cycle_count;
    int unsigned    items_queued, detects_queued, configs_written;
    int             px_idle_pct, res_stall_pct;
    int             px_gap, res_gap;

    // Generator-side view of which store entries hold data. The stores
    // come out of reset undefined, so no transaction may read an entry
    // before it is written: detect reads the background, and a learn add
    // (or a multi-frame learn last) reads the sums.
    bit          bg_known  [0:PIXEL_COUNT-1];
    bit          sum_known [0:PIXEL_COUNT-1];
    int unsigned gen_frames = 1;
    bit [15:0]   recent_pixels[$];

    initial begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction: apply one accepted pixel to the shadow state, queue the
    // difference result when the mode is detect.
    // ------------------------------------------------------------------
    function automatic void absorb_pixel(rabs_pkg::pix_t p);
        int unsigned    n, a, b, v, q;
        bit [7:0]       px [0:rabs_pkg::CHANNELS-1];
        bit [7:0]       d  [0:rabs_pkg::CHANNELS-1];
        bit [15:0]      acc;
        bit             restart;
        rabs_pkg::res_t r;
        px[0] = p.red_in;
        px[1] = p.green_in;
        px[2] = p.blue_in;
        // out-of-range settings clamp: alpha to 256, frame count to 1..256
        a = (alpha_cfg > rabs_pkg::ALPHA_MAX) ? 32'(rabs_pkg::ALPHA_MAX) : 32'(alpha_cfg);
        if (frames_cfg == 0)
            n = 1;
        else if (frames_cfg > MAX_LEARN_FRAMES)
            n = MAX_LEARN_FRAMES;
        else
            n = 32'(frames_cfg);

        if (p.mode == rabs_pkg::MODE_DETECT) begin
            for (int k = 0; k < rabs_pkg::CHANNELS; k++) begin
                b    = 32'(bg_mem[p.pixel_index][k]);
                d[k] = 8'((px[k] >= b) ? px[k] - b : b - px[k]);
                // blend toward the pixel, truncated
                v    = (a * b + (32'(rabs_pkg::ALPHA_MAX) - a) * px[k]) >> 8;
                bg_mem[p.pixel_index][k] = v[7:0];
            end
            r.pixel_out  = p.pixel_index;
            r.red_diff   = d[0];
            r.green_diff = d[1];
            r.blue_diff  = d[2];
            expected_diffs.push_back(r);
        end
        else begin
            // first frame restarts the sums; so does a last frame when the count is one
            restart = (p.mode == rabs_pkg::MODE_LEARN_FIRST) ||
                      (p.mode == rabs_pkg::MODE_LEARN_LAST && n == 1);
            for (int k = 0; k < rabs_pkg::CHANNELS; k++) begin
                if (restart)
                    acc = 16'(px[k]);
                else
                    acc = sum_mem[p.pixel_index][k] + px[k];   // 16-bit wrap
                sum_mem[p.pixel_index][k] = acc;
                if (p.mode == rabs_pkg::MODE_LEARN_LAST) begin
                    q = acc / n;
                    bg_mem[p.pixel_index][k] = (q > 255) ? 8'd255 : q[7:0];
                end
            end
        end
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got,
                                        int unsigned seq);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s: expected %0d, got %0d", seq, name, want, got));
    endfunction

    // ------------------------------------------------------------------
    // Monitor: samples at the rising edge. Config and pixel transactions
    // feed the shadow model, result transactions are checked in order.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        rabs_pkg::res_t want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == rabs_pkg::CFG_LEARN_FRAMES)
                    frames_cfg = cfg_data;
                else
                    alpha_cfg = cfg_data;
                cfg_taken++;
            end
            if (px_valid && px_ready) begin
                absorb_pixel(px_data);
                px_taken++;
            end
            if (res_valid && res_ready) begin
                if (expected_diffs.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result: pixel %0d diffs %0d %0d %0d",
                                            res_data.pixel_out, res_data.red_diff,
                                            res_data.green_diff, res_data.blue_diff));
                end
                else begin
                    want = expected_diffs.pop_front();
                    check_field("pixel_out", want.pixel_out, res_data.pixel_out,
                                results_checked);
                    check_field("red_diff", 16'(want.red_diff), 16'(res_data.red_diff),
                                results_checked);
                    check_field("green_diff", 16'(want.green_diff), 16'(res_data.green_diff),
                                results_checked);
                    check_field("blue_diff", 16'(want.blue_diff), 16'(res_data.blue_diff),
                                results_checked);
                    results_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: changes inputs at the falling edge. A valid that is up stays
    // up with the same payload until the monitor has seen the transaction.
    // Pixel idle and result stall bursts start at random, at the set percentages.
    // ------------------------------------------------------------------
    always @(negedge clk) begin : driver
        cfg_write_t w;
        if (rst_n) begin
            // pixel channel
            if (!(px_valid && px_taken != px_issued)) begin
                if (px_gap > 0) begin
                    px_gap--;
                    px_valid <= 1'b0;
                end
                else if (pending_pixels.size() != 0 && $urandom_range(1, 100) <= px_idle_pct) begin
                    px_gap   = $urandom_range(1, 13) - 1;
                    px_valid <= 1'b0;
                end
                else if (pending_pixels.size() != 0) begin
                    px_data  <= pending_pixels.pop_front();
                    px_valid <= 1'b1;
                    px_issued++;
                end
                else begin
                    px_valid <= 1'b0;
                end
            end

            // result back-pressure
            if (res_gap > 0) begin
                res_gap--;
                res_ready <= 1'b0;
            end
            else if ($urandom_range(1, 100) <= res_stall_pct) begin
                res_gap   = $urandom_range(1, 13) - 1;
                res_ready <= 1'b0;
            end
            else begin
                res_ready <= 1'b1;
            end

            // config channel, only fed while the datapath is drained
            if (!(cfg_valid && cfg_taken != cfg_issued)) begin
                if (pending_cfg.size() != 0) begin
                    w = pending_cfg.pop_front();
                    cfg_index <= w.index;
                    cfg_data  <= w.data;
                    cfg_valid <= 1'b1;
                    cfg_issued++;
                end
                else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, expected_diffs.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Block until every queued pixel is accepted and every difference has
    // come back, then give the pipeline time to retire learn transactions,
    // which leave no result behind.
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_pixels.size() != 0 || px_taken != px_issued || expected_diffs.size() != 0);
        repeat (DRAIN_PAD) @(negedge clk);
    endtask

    task automatic set_config(input bit [8:0] frames, input bit [8:0] alpha);
        cfg_write_t w;
        wait_drained();
        w.index = rabs_pkg::CFG_LEARN_FRAMES;
        w.data  = frames;
        pending_cfg.push_back(w);
        w.index = rabs_pkg::CFG_ALPHA_Q8;
        w.data  = alpha;
        pending_cfg.push_back(w);
        do @(negedge clk);
        while (pending_cfg.size() != 0 || cfg_taken != cfg_issued);
        if (frames == 0)
            gen_frames = 1;
        else if (frames > MAX_LEARN_FRAMES)
            gen_frames = MAX_LEARN_FRAMES;
        else
            gen_frames = 32'(frames);
        configs_written += 2;
    endtask

    // Queue one pixel; a mode that would read an unwritten entry is turned
    // into the learn mode that writes it first.
    task automatic queue_pixel(input rabs_pkg::mode_t m, input bit [15:0] idx,
                               input bit [7:0] r, input bit [7:0] g, input bit [7:0] b);
        rabs_pkg::pix_t p;
        if (m == rabs_pkg::MODE_DETECT && !bg_known[idx]) begin
            if (gen_frames == 1 || sum_known[idx])
                m = rabs_pkg::MODE_LEARN_LAST;
            else
                m = rabs_pkg::MODE_LEARN_FIRST;
        end
        if ((m == rabs_pkg::MODE_LEARN_ADD ||
             (m == rabs_pkg::MODE_LEARN_LAST && gen_frames > 1)) && !sum_known[idx])
            m = rabs_pkg::MODE_LEARN_FIRST;

        if (m == rabs_pkg::MODE_DETECT) begin
            bg_known[idx] = 1'b1;
            detects_queued++;
        end
        else begin
            sum_known[idx] = 1'b1;
            if (m == rabs_pkg::MODE_LEARN_LAST)
                bg_known[idx] = 1'b1;
        end

        p.mode        = m;
        p.pixel_index = idx;
        p.red_in      = r;
        p.green_in    = g;
        p.blue_in     = b;
        pending_pixels.push_back(p);
        items_queued++;
        recent_pixels.push_back(idx);
        if (recent_pixels.size() > 32)
            void'(recent_pixels.pop_front());
    endtask

    function automatic bit [15:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3, 4:
                if (recent_pixels.size() != 0)
                    return recent_pixels[$urandom_range(0, recent_pixels.size() - 1)];
            default: ;
        endcase
        return 16'($urandom);
    endfunction

    // hot: channels near full scale, to push the 16-bit sums past wrap
    function automatic bit [7:0] rand_chan(bit hot);
        if (hot)
            return 8'($urandom_range(200, 255));
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // A well-formed run over a few pixels: first frame, adds, last frame,
    // then detect frames. Extra adds make the average saturate (or wrap).
    task automatic run_sequence(input int width, input int extra, input int detects,
                                input bit hot);
        bit [15:0]       pix[$];
        rabs_pkg::mode_t m;
        int              frames;
        repeat (width) pix.push_back(pick_pixel());
        frames = gen_frames + extra;
        for (int f = 0; f < frames; f++) begin
            if (f == frames - 1)
                m = rabs_pkg::MODE_LEARN_LAST;
            else if (f == 0)
                m = rabs_pkg::MODE_LEARN_FIRST;
            else
                m = rabs_pkg::MODE_LEARN_ADD;
            foreach (pix[i])
                queue_pixel(m, pix[i], rand_chan(hot), rand_chan(hot), rand_chan(hot));
        end
        repeat (detects)
            foreach (pix[i])
                queue_pixel(rabs_pkg::MODE_DETECT, pix[i],
                            rand_chan(1'b0), rand_chan(1'b0), rand_chan(1'b0));
    endtask

    task automatic run_random(input int unsigned budget);
        int unsigned stop;
        stop = items_queued + budget;
        while (items_queued < stop) begin
            if ($urandom_range(0, 9) < 8) begin
                run_sequence((gen_frames > 64) ? 1 : int'($urandom_range(1, 4)),
                             ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0,
                             $urandom_range(1, 6), 1'b0);
            end
            else begin
                // broken sequences: any mode on any pixel
                repeat ($urandom_range(1, 10))
                    queue_pixel(rabs_pkg::mode_t'($urandom_range(0, 3)), pick_pixel(),
                                rand_chan(1'b0), rand_chan(1'b0), rand_chan(1'b0));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        bit [8:0] frames_set [RANDOM_PHASES] = '{9'd511, 9'd256, 9'd3, 9'd1, 9'd5, 9'd2, 9'd4};
        bit [8:0] alpha_set  [RANDOM_PHASES] = '{9'd511, 9'd128, 9'd1, 9'd243, 9'd255, 9'd300, 9'd200};
        bit       quiet;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset settings (one learn frame, alpha 243).
        // A lone last frame replaces the sums and sets the background.
        px_idle_pct   = 10;
        res_stall_pct = 20;
        queue_pixel(rabs_pkg::MODE_LEARN_LAST,  16'h0000, 8'd255, 8'd0,   8'd128);
        queue_pixel(rabs_pkg::MODE_DETECT,      16'h0000, 8'd0,   8'd255, 8'd128);
        queue_pixel(rabs_pkg::MODE_DETECT,      16'h0000, 8'd255, 8'd255, 8'd255);
        queue_pixel(rabs_pkg::MODE_LEARN_FIRST, 16'hFFFF, 8'd0,   8'd0,   8'd0);
        queue_pixel(rabs_pkg::MODE_LEARN_ADD,   16'hFFFF, 8'd255, 8'd255, 8'd255);
        queue_pixel(rabs_pkg::MODE_LEARN_LAST,  16'hFFFF, 8'd10,  8'd20,  8'd30);
        queue_pixel(rabs_pkg::MODE_DETECT,      16'hFFFF, 8'd0,   8'd0,   8'd0);
        queue_pixel(rabs_pkg::MODE_DETECT,      16'hFFFF, 8'd255, 8'd0,   8'd255);
        queue_pixel(rabs_pkg::MODE_DETECT,      16'h0000, 8'd0,   8'd0,   8'd0);

        // Two-frame average with two adds too many: quotient saturates at 255.
        // Alpha zero makes the background follow the pixel outright.
        set_config(9'd2, 9'd0);
        queue_pixel(rabs_pkg::MODE_LEARN_FIRST, 16'h0001, 8'd255, 8'd255, 8'd255);
        queue_pixel(rabs_pkg::MODE_LEARN_ADD,   16'h0001, 8'd255, 8'd255, 8'd255);
        queue_pixel(rabs_pkg::MODE_LEARN_ADD,   16'h0001, 8'd255, 8'd0,   8'd255);
        queue_pixel(rabs_pkg::MODE_LEARN_LAST,  16'h0001, 8'd255, 8'd255, 8'd0);
        queue_pixel(rabs_pkg::MODE_DETECT,      16'h0001, 8'd0,   8'd128, 8'd255);
        queue_pixel(rabs_pkg::MODE_DETECT,      16'h0001, 8'd7,   8'd7,   8'd7);

        // Frame count of zero acts as one; alpha 256 freezes the background.
        set_config(9'd0, rabs_pkg::ALPHA_MAX);
        queue_pixel(rabs_pkg::MODE_LEARN_LAST,  16'h0002, 8'd100, 8'd150, 8'd200);
        queue_pixel(rabs_pkg::MODE_DETECT,      16'h0002, 8'd0,   8'd255, 8'd1);
        queue_pixel(rabs_pkg::MODE_DETECT,      16'h0002, 8'd100, 8'd150, 8'd200);

        // Random phases, each after a full drain and a register update.
        // Above-range frame counts and alphas are among the settings.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_config(frames_set[ph], alpha_set[ph]);
            quiet         = (ph == RANDOM_PHASES - 1) || (ph == 3);
            px_idle_pct   = quiet ? 0 : int'($urandom_range(5, 25));
            res_stall_pct = quiet ? 0 : int'($urandom_range(5, 40));
            if (frames_set[ph] == 9'd256)
                // 328 near-full frames on one pixel: channel sums wrap before the average
                run_sequence(1, 72, 4, 1'b1);
            else
                run_random(220);
        end

        wait_drained();
        $display("covered %0d pixel transactions (%0d detect), %0d differences checked",
                 items_queued, detects_queued, results_checked);
        $display("covered %0d register writes over %0d settings, %0d mismatches",
                 configs_written, RANDOM_PHASES + 2, mismatches);
        if (mismatches == 0 && expected_diffs.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
